// ===== rtl/pa_pkg.sv =====
package pa_pkg;

  localparam int unsigned IndexWidth = 32;
  localparam int unsigned CountWidth = 2;

  typedef logic [IndexWidth-1:0] index_t;
  typedef logic [CountWidth-1:0] count_t;

  typedef enum logic [2:0] {
    ARR_TRI_LIST   = 3'd0,
    ARR_TRI_STRIP  = 3'd1,
    ARR_LINE_LIST  = 3'd2,
    ARR_LINE_STRIP = 3'd3,
    ARR_TRI_FAN    = 3'd4
  } arrangement_t;

  typedef struct packed {
    index_t vertex_index;
    logic   list_start;
  } item_t;

  typedef struct packed {
    index_t corner_a;
    index_t corner_b;
    index_t corner_c;
  } prim_t;

  // handshake between the input register and the assembly stage
  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctl_t;

endpackage

// ===== rtl/pa_input_stage.sv =====
module pa_input_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              idx_valid,
  output logic              idx_stall,
  input  pa_pkg::item_t     item_in,
  input  logic              advance,
  output pa_pkg::stage_ctl_t ctl,
  output pa_pkg::item_t     item
);

  logic held;
  logic take;

  assign idx_stall = held && !advance;
  assign take      = idx_valid && !idx_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (take) begin
      held <= 1'b1;
    end else if (advance) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item <= item_in;
    end
  end

  assign ctl.valid   = held;
  assign ctl.advance = advance;

endmodule

// ===== rtl/pa_assembler.sv =====
module pa_assembler (
  input  logic                 clk,
  input  logic                 rst,
  input  pa_pkg::arrangement_t arrangement,
  input  pa_pkg::stage_ctl_t   ctl,
  input  pa_pkg::item_t        item,
  output logic                 prim_valid,
  input  logic                 prim_stall,
  output logic                 advance,
  output pa_pkg::prim_t        prim
);

  pa_pkg::index_t older_index;
  pa_pkg::index_t newer_index;
  pa_pkg::index_t hub_index;
  pa_pkg::count_t list_position;
  pa_pkg::count_t group_phase;

  pa_pkg::count_t pos;
  pa_pkg::count_t phase;
  pa_pkg::index_t hub_next;
  pa_pkg::count_t list_position_next;
  pa_pkg::count_t group_phase_next;
  pa_pkg::prim_t  prim_next;
  logic           emit;
  logic           out_full;
  logic           consume;

  assign advance = !out_full || !prim_stall;
  assign consume = ctl.valid && ctl.advance;

  always_comb begin
    pos      = item.list_start ? '0 : list_position;
    phase    = item.list_start ? '0 : group_phase;
    hub_next = (pos == '0) ? item.vertex_index : hub_index;
    list_position_next = (pos >= 2'd2) ? 2'd2 : pos + 2'd1;
  end

  always_comb begin
    emit             = 1'b0;
    group_phase_next = '0;
    prim_next        = '{corner_a: older_index, corner_b: newer_index,
                         corner_c: item.vertex_index};
    unique case (arrangement)
      pa_pkg::ARR_TRI_LIST: begin
        if (phase >= 2'd2) begin
          emit = 1'b1;
        end else begin
          group_phase_next = phase + 2'd1;
        end
      end
      pa_pkg::ARR_TRI_STRIP: begin
        emit = (pos >= 2'd2);
      end
      pa_pkg::ARR_LINE_LIST: begin
        prim_next = '{corner_a: newer_index, corner_b: item.vertex_index,
                      corner_c: newer_index};
        if (phase >= 2'd1) begin
          emit = 1'b1;
        end else begin
          group_phase_next = 2'd1;
        end
      end
      pa_pkg::ARR_LINE_STRIP: begin
        prim_next = '{corner_a: newer_index, corner_b: item.vertex_index,
                      corner_c: newer_index};
        emit = (pos >= 2'd1);
      end
      pa_pkg::ARR_TRI_FAN: begin
        prim_next = '{corner_a: hub_next, corner_b: newer_index,
                      corner_c: item.vertex_index};
        emit = (pos >= 2'd2);
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      older_index   <= '0;
      newer_index   <= '0;
      hub_index     <= '0;
      list_position <= '0;
      group_phase   <= '0;
    end else if (consume) begin
      older_index   <= newer_index;
      newer_index   <= item.vertex_index;
      hub_index     <= hub_next;
      list_position <= list_position_next;
      group_phase   <= group_phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (advance) begin
      out_full <= consume && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && emit && advance) begin
      prim <= prim_next;
    end
  end

  assign prim_valid = out_full;

endmodule

// ===== rtl/primitive_assembler.sv =====
// channel   | beat                      | valid       | stall
// ----------+---------------------------+-------------+------------
// index in  | vertex_index, list_start  | idx_valid   | idx_stall
// prim out  | corner_a/b/c              | prim_valid  | prim_stall
// config    | cfg_data (arrangement)    | cfg_write   | none
//
// One index beat per cycle while idx_stall is low; a primitive is valid once its last index
// has passed the input register and the single assembly stage into the result register.
// rst is synchronous: clears list state, arrangement returns to triangle list.
// prim_stall holds the result register; idx_stall rises only when both registers are full
// and prim_stall is high.
module primitive_assembler (
  input  logic        clk,
  input  logic        rst,
  input  logic        idx_valid,
  output logic        idx_stall,
  input  logic [31:0] vertex_index,
  input  logic        list_start,
  output logic        prim_valid,
  input  logic        prim_stall,
  output logic [31:0] corner_a,
  output logic [31:0] corner_b,
  output logic [31:0] corner_c,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_data
);

  pa_pkg::arrangement_t arrangement;
  pa_pkg::stage_ctl_t   ctl;
  pa_pkg::item_t        item_in;
  pa_pkg::item_t        item;
  pa_pkg::prim_t        prim;
  logic                 advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      arrangement <= pa_pkg::ARR_TRI_LIST;
    end else if (cfg_write) begin
      arrangement <= pa_pkg::arrangement_t'(cfg_data);
    end
  end

  assign item_in = '{vertex_index: vertex_index, list_start: list_start};

  pa_input_stage u_input (
    .clk       (clk),
    .rst       (rst),
    .idx_valid (idx_valid),
    .idx_stall (idx_stall),
    .item_in   (item_in),
    .advance   (advance),
    .ctl       (ctl),
    .item      (item)
  );

  pa_assembler u_assemble (
    .clk         (clk),
    .rst         (rst),
    .arrangement (arrangement),
    .ctl         (ctl),
    .item        (item),
    .prim_valid  (prim_valid),
    .prim_stall  (prim_stall),
    .advance     (advance),
    .prim        (prim)
  );

  assign corner_a = prim.corner_a;
  assign corner_b = prim.corner_b;
  assign corner_c = prim.corner_c;

endmodule
